### src/hfa_pkg.sv
// ----------------------------------------------------------------------------
// hfa_pkg
// Shared types and codes for the hole fit allocator: transfer payloads,
// operation modes, result status codes and placement policies.
// ----------------------------------------------------------------------------
`default_nettype none

package hfa_pkg;

	// default table depth
	localparam int unsigned DEF_MAX_HOLES = 16;

	// field widths
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned AMOUNT_W = 16;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned HIDX_W   = 4;
	localparam int unsigned FRAG_W   = 20;
	localparam int unsigned POLICY_W = 2;

	// saturation ceiling of the fragmentation sum
	localparam logic [FRAG_W-1:0] FRAG_MAX = {FRAG_W{1'b1}};

	// operation modes
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOFIT   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

	// placement policies, any other code behaves as first fit
	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

	// input item
	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [AMOUNT_W-1:0] amount;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HIDX_W-1:0]   hole_index;
		logic [AMOUNT_W-1:0] remaining;
		logic [FRAG_W-1:0]   frag_total;
	} out_item_t;

endpackage : hfa_pkg

`default_nettype wire

### src/hole_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// hole_fit_allocator_top
// Free hole table with first, best and worst fit placement of requests.
// ----------------------------------------------------------------------------
// Holes are appended one per load, up to MAX_HOLES, and a clear empties the
// table and leaves the halted state. A load, clear or refused item, and an
// allocate on an empty table, goes from S_IDLE straight to S_DONE. Any
// other allocate runs a scan over the loaded holes with one compare/subtract
// unit fed from the hole memory's single read port, one hole per cycle, then
// passes S_LAST and S_DECIDE. The scan also sums all hole space; when no
// hole fits, that saturated sum is reported and the block refuses loads and
// allocates until the next clear. The result sits in an output register, so
// a new item is taken while it waits. fit_policy is written on its own
// channel, which is always ready, and must only change while no item is in
// progress.
// ----------------------------------------------------------------------------
`default_nettype none

module hole_fit_allocator_top #(
	parameter int unsigned MAX_HOLES = hfa_pkg::DEF_MAX_HOLES
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [hfa_pkg::POLICY_W-1:0] cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire hfa_pkg::in_item_t            in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output hfa_pkg::out_item_t                out_data
);

	import hfa_pkg::*;

	localparam int unsigned IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int unsigned CW = $clog2(MAX_HOLES + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_HOLES);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_DECIDE,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [POLICY_W-1:0]   fit_policy_q;
	logic [CW-1:0]         count_q;
	logic                  halted_q;
	logic [AMOUNT_W-1:0]   amount_q;
	logic [CW-1:0]         scan_q;
	logic                  found_q;
	logic [IW-1:0]         pick_q;
	logic [AMOUNT_W-1:0]   best_q;
	logic [FRAG_W-1:0]     sum_q;
	out_item_t             res_q;
	logic                  out_valid_q;
	out_item_t             out_data_q;

	logic                  rd_vld_s1;
	logic [IW-1:0]         rd_idx_s1;
	logic [AMOUNT_W-1:0]   rd_data_s1;

	logic [AMOUNT_W-1:0]   mem [MAX_HOLES];
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	logic [AMOUNT_W-1:0]   mem_wdata;

	logic                  fits;
	logic [AMOUNT_W-1:0]   left;
	logic                  take;
	logic [FRAG_W:0]       sum_add;
	logic [FRAG_W-1:0]     sum_next;
	logic [IW+HIDX_W-1:0]  pick_ext;
	logic [CW+HIDX_W-1:0]  cnt_ext;
	logic                  in_xfer;
	logic                  out_free;

	// result item from its fields
	function automatic out_item_t make_result(
		input logic [STATUS_W-1:0] status,
		input logic [HIDX_W-1:0]   hole_index,
		input logic [AMOUNT_W-1:0] remaining,
		input logic [FRAG_W-1:0]   frag_total
	);
		out_item_t r;
		r.status     = status;
		r.hole_index = hole_index;
		r.remaining  = remaining;
		r.frag_total = frag_total;
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// hole index as reported, low bits of the table index
	assign pick_ext = {{HIDX_W{1'b0}}, pick_q};
	assign cnt_ext  = {{HIDX_W{1'b0}}, count_q};

	// shared compare / subtract unit on the hole just read
	always_comb begin
		fits = (rd_data_s1 >= amount_q);
		left = rd_data_s1 - amount_q;
		take = 1'b0;
		if (rd_vld_s1 && fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (fit_policy_q == POL_BEST) begin
				take = (left < best_q);
			end else if (fit_policy_q == POL_WORST) begin
				take = (left > best_q);
			end
		end
		sum_add  = {1'b0, sum_q} + {{(FRAG_W + 1 - AMOUNT_W){1'b0}}, rd_data_s1};
		sum_next = (sum_add > {1'b0, FRAG_MAX}) ? FRAG_MAX : sum_add[FRAG_W-1:0];
	end

	// memory write port: loads and the shrink of the chosen hole
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pick_q;
		mem_wdata = best_q;
		if (state_q == S_IDLE && in_xfer && in_data.mode == MODE_LOAD && !halted_q &&
				count_q < CNT_FULL) begin
			mem_we    = 1'b1;
			mem_waddr = count_q[IW-1:0];
			mem_wdata = in_data.amount;
		end else if (state_q == S_DECIDE && found_q) begin
			mem_we = 1'b1;
		end
	end

	// hole memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == S_SCAN) begin
			rd_data_s1 <= mem[scan_q[IW-1:0]];
		end
	end

	// sequencer, table state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fit_policy_q <= POL_FIRST;
			count_q      <= '0;
			halted_q     <= 1'b0;
			found_q      <= 1'b0;
			scan_q       <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
			amount_q     <= '0;
			pick_q       <= '0;
			best_q       <= '0;
			sum_q        <= '0;
			rd_idx_s1    <= '0;
			res_q        <= '0;
			out_data_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fit_policy_q <= cfg_data;
			end
			// output register drains unless a new result replaces it
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			// compare stage, runs for each hole read
			if (take) begin
				found_q <= 1'b1;
				pick_q  <= rd_idx_s1;
				best_q  <= left;
			end
			if (rd_vld_s1) begin
				sum_q <= sum_next;
			end

			case (state_q)
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (in_xfer) begin
						amount_q <= in_data.amount;
						if (in_data.mode == MODE_CLEAR) begin
							count_q  <= '0;
							halted_q <= 1'b0;
							res_q    <= make_result(ST_LOADED, '0, '0, '0);
							state_q  <= S_DONE;
						end else if (in_data.mode != MODE_LOAD &&
								in_data.mode != MODE_ALLOC) begin
							res_q   <= make_result(ST_REFUSED, '0, '0, '0);
							state_q <= S_DONE;
						end else if (halted_q) begin
							res_q   <= make_result(ST_REFUSED, '0, '0, '0);
							state_q <= S_DONE;
						end else if (in_data.mode == MODE_LOAD) begin
							if (count_q >= CNT_FULL) begin
								res_q <= make_result(ST_FULL, '0, '0, '0);
							end else begin
								res_q   <= make_result(ST_LOADED, cnt_ext[HIDX_W-1:0],
									'0, '0);
								count_q <= count_q + CNT_ONE;
							end
							state_q <= S_DONE;
						end else if (count_q == '0) begin
							// empty table never fits
							res_q    <= make_result(ST_NOFIT, '0, '0, '0);
							halted_q <= 1'b1;
							state_q  <= S_DONE;
						end else begin
							scan_q  <= '0;
							found_q <= 1'b0;
							sum_q   <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_vld_s1 <= 1'b1;
					rd_idx_s1 <= scan_q[IW-1:0];
					scan_q    <= scan_q + CNT_ONE;
					if (scan_q + CNT_ONE == count_q) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					// last hole is compared this cycle
					rd_vld_s1 <= 1'b0;
					state_q   <= S_DECIDE;
				end
				S_DECIDE: begin
					if (found_q) begin
						res_q <= make_result(ST_ALLOC, pick_ext[HIDX_W-1:0], best_q, '0);
					end else begin
						res_q    <= make_result(ST_NOFIT, '0, '0, sum_q);
						halted_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_data_q  <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule : hole_fit_allocator_top

`default_nettype wire
